[rtl/core/bvrs_pkg.sv]
// shared types, constants and popcount for the rank/select bit vector
package bvrs_pkg;

  localparam int unsigned MAX_WORDS = 1024;
  localparam int unsigned WORD_AW   = 10;
  localparam int unsigned WPC_LOG   = 3;
  localparam int unsigned CHUNK_AW  = WORD_AW - WPC_LOG;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned WC_W      = 11;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_RANK  = 2'd1,
    KIND_SEL0  = 2'd2,
    KIND_SEL1  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  word_addr;
    logic [31:0] word_data;
    logic [15:0] query_value;
  } item_t;

  function automatic logic [5:0] ones32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = x - ((x >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    return 6'(c[7:0] + c[15:8] + c[23:16] + c[31:24]);
  endfunction

endpackage

[rtl/core/bvrs_ram.sv]
// single-port synchronous ram with registered read data
module bvrs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

[rtl/core/bvrs_engine.sv]
// sequencer for word writes, rank and select over word and chunk-count memories
module bvrs_engine import bvrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  item_t             item_i,
  input  logic [WC_W-1:0]   wc_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       result_value_o,
  output logic              out_of_range_o
);
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_W_RD, ST_W_WR,
    ST_R_CH_RD, ST_R_CH_USE, ST_R_W_RD, ST_R_W_USE, ST_R_P_USE,
    ST_S_CH_RD, ST_S_CH_USE, ST_S_W_RD, ST_S_W_USE, ST_S_PICK, ST_DONE
  } state_e;

  state_e              state_q;
  item_t               item_q;
  logic [WORD_AW-1:0]  clr_q;
  logic [15:0]         n_q, sum_q, res_q;
  logic                err_q;
  logic [7:0]          c_idx_q;
  logic [10:0]         w_idx_q, end_q;
  logic [31:0]         word_q;
  logic [4:0]          bit_q;
  logic                out_valid_q;
  logic [15:0]         out_value_q;
  logic                out_err_q;

  logic                w_we, c_we;
  logic [WORD_AW-1:0]  w_addr;
  logic [CHUNK_AW-1:0] c_addr;
  logic [31:0]         w_wdata, w_rdata;
  logic [CNT_W-1:0]    c_wdata, c_rdata;

  logic [10:0]         full;
  logic [7:0]          chunks;
  logic [4:0]          rem;
  logic [10:0]         start;
  logic                sel1;
  logic [CNT_W-1:0]    cnt;
  logic [31:0]         sel_word;
  logic [5:0]          k;

  assign full     = item_q.query_value[15:5];
  assign chunks   = full[10:3];
  assign rem      = item_q.query_value[4:0];
  assign start    = {c_idx_q, 3'b000};
  assign sel1     = (item_q.kind == KIND_SEL1);
  assign cnt      = sel1 ? c_rdata : CNT_W'(9'd256 - c_rdata);
  assign sel_word = sel1 ? w_rdata : ~w_rdata;
  assign k        = ones32(sel_word);

  always_comb begin
    w_we    = 1'b0;
    c_we    = 1'b0;
    w_addr  = w_idx_q[WORD_AW-1:0];
    c_addr  = c_idx_q[CHUNK_AW-1:0];
    w_wdata = item_q.word_data;
    c_wdata = CNT_W'(c_rdata + {3'b000, ones32(item_q.word_data)} - {3'b000, ones32(w_rdata)});
    case (state_q)
      ST_CLEAR: begin
        w_we    = 1'b1;
        c_we    = 1'b1;
        w_addr  = clr_q;
        c_addr  = clr_q[CHUNK_AW-1:0];
        w_wdata = '0;
        c_wdata = '0;
      end
      ST_W_RD: begin
        w_addr = item_q.word_addr;
        c_addr = item_q.word_addr[WORD_AW-1:WPC_LOG];
      end
      ST_W_WR: begin
        w_we   = 1'b1;
        c_we   = 1'b1;
        w_addr = item_q.word_addr;
        c_addr = item_q.word_addr[WORD_AW-1:WPC_LOG];
      end
      default: ;
    endcase
  end

  bvrs_ram #(.Width(32), .Depth(MAX_WORDS)) u_words (
    .clk_i, .we_i(w_we), .addr_i(w_addr), .wdata_i(w_wdata), .rdata_o(w_rdata)
  );

  bvrs_ram #(.Width(CNT_W), .Depth(MAX_WORDS >> WPC_LOG)) u_chunks (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wdata), .rdata_o(c_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= item_i;
            n_q     <= item_i.query_value;
            sum_q   <= '0;
            c_idx_q <= '0;
            res_q   <= '0;
            err_q   <= 1'b1;
            case (item_i.kind)
              KIND_WRITE: state_q <= ST_W_RD;
              KIND_RANK: begin
                if (item_i.query_value > {wc_i, 5'b00000}) begin
                  state_q <= ST_DONE;
                end else begin
                  state_q <= ST_R_CH_RD;
                end
              end
              default: begin
                if (item_i.query_value == '0) begin
                  state_q <= ST_DONE;
                end else begin
                  state_q <= ST_S_CH_RD;
                end
              end
            endcase
          end
        end
        ST_W_RD: state_q <= ST_W_WR;
        ST_W_WR: state_q <= ST_IDLE;
        ST_R_CH_RD: begin
          if (c_idx_q == chunks) begin
            w_idx_q <= {chunks, 3'b000};
            state_q <= ST_R_W_RD;
          end else begin
            state_q <= ST_R_CH_USE;
          end
        end
        ST_R_CH_USE: begin
          sum_q   <= sum_q + 16'(c_rdata);
          c_idx_q <= c_idx_q + 1'b1;
          state_q <= ST_R_CH_RD;
        end
        ST_R_W_RD: begin
          if (w_idx_q == full) begin
            if (rem != '0 && !full[10]) begin
              state_q <= ST_R_P_USE;
            end else begin
              res_q   <= sum_q;
              err_q   <= 1'b0;
              state_q <= ST_DONE;
            end
          end else begin
            state_q <= ST_R_W_USE;
          end
        end
        ST_R_W_USE: begin
          sum_q   <= sum_q + 16'(ones32(w_rdata));
          w_idx_q <= w_idx_q + 1'b1;
          state_q <= ST_R_W_RD;
        end
        ST_R_P_USE: begin
          res_q   <= sum_q + 16'(ones32(w_rdata & ~(32'hFFFF_FFFF << rem)));
          err_q   <= 1'b0;
          state_q <= ST_DONE;
        end
        ST_S_CH_RD: begin
          if (start >= wc_i) begin
            state_q <= ST_DONE;
          end else if ({1'b0, start} + 12'd8 <= {1'b0, wc_i}) begin
            state_q <= ST_S_CH_USE;
          end else begin
            end_q   <= wc_i;
            w_idx_q <= start;
            state_q <= ST_S_W_RD;
          end
        end
        ST_S_CH_USE: begin
          if (16'(cnt) < n_q) begin
            n_q     <= n_q - 16'(cnt);
            c_idx_q <= c_idx_q + 1'b1;
            state_q <= ST_S_CH_RD;
          end else begin
            end_q   <= start + 11'd8;
            w_idx_q <= start;
            state_q <= ST_S_W_RD;
          end
        end
        ST_S_W_RD: begin
          if (w_idx_q == end_q) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_S_W_USE;
          end
        end
        ST_S_W_USE: begin
          if (16'(k) >= n_q) begin
            word_q  <= sel_word;
            bit_q   <= '0;
            state_q <= ST_S_PICK;
          end else begin
            n_q     <= n_q - 16'(k);
            w_idx_q <= w_idx_q + 1'b1;
            state_q <= ST_S_W_RD;
          end
        end
        ST_S_PICK: begin
          if (word_q[0]) begin
            if (n_q == 16'd1) begin
              res_q   <= {w_idx_q, bit_q};
              err_q   <= 1'b0;
              state_q <= ST_DONE;
            end else begin
              n_q <= n_q - 1'b1;
            end
          end
          word_q <= word_q >> 1;
          bit_q  <= bit_q + 1'b1;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_q;
            out_err_q   <= err_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign out_of_range_o = out_err_q;
endmodule

[rtl/core/bit_vector_rank_select.sv]
// top level of the rank/select bit vector with its register port
//
// channel  direction  handshake            payload
// in       input      in_valid_i/in_stall_o  kind_i word_addr_i word_data_i query_value_i
// out      output     out_valid_o/out_stall_i result_value_o out_of_range_o
// cfg      apb        psel penable pwrite   paddr pwdata prdata (word_count at 0)
//
// a write item reads the word and its chunk count, then writes both back
// rank sums chunk counts, then word popcounts, then a masked partial word when n%32 is nonzero
// select visits chunks, then words, then steps through the bits of the chosen word
// after reset a sweep clears both memories while in_stall_o is high
// a result waits in the output register while the next item is accepted
module bit_vector_rank_select import bvrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [9:0]  word_addr_i,
  input  logic [31:0] word_data_i,
  input  logic [15:0] query_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_value_o,
  output logic        out_of_range_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [WC_W-1:0] word_count_q;
  logic [WC_W-1:0] wc;
  item_t           item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      word_count_q <= pwdata[WC_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {21'd0, word_count_q};
  assign wc     = (word_count_q > WC_W'(MAX_WORDS)) ? WC_W'(MAX_WORDS) : word_count_q;

  assign item.kind        = kind_e'(kind_i);
  assign item.word_addr   = word_addr_i;
  assign item.word_data   = word_data_i;
  assign item.query_value = query_value_i;

  bvrs_engine u_engine (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .item_i(item), .wc_i(wc),
    .out_valid_o, .out_stall_i, .result_value_o, .out_of_range_o
  );

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> result_value_o == 16'd0)
    else $error("error result with nonzero value");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after accepting an item");
endmodule
